/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the markup tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define JMT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tokenizer same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define JMT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tokenizer next-cycle check failed");
`else
`define JMT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define JMT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/jmt_pkg.sv */
// Shared types, character codes and token kinds of the markup tokenizer.
package jmt_pkg;

    localparam int POS_BITS_DEF  = 16;
    localparam int LINE_BITS_DEF = 16;
    localparam int TOK_W         = 16;
    localparam int MAX_RES       = 3;

    // Source characters.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOT  = 8'h22;
    localparam logic [7:0] CH_SQUOT  = 8'h27;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Scan modes.
    localparam logic [2:0] MODE_NAME    = 3'd0;
    localparam logic [2:0] MODE_TEXT    = 3'd1;
    localparam logic [2:0] MODE_COMMENT = 3'd2;
    localparam logic [2:0] MODE_DQ      = 3'd3;

    // Kind of the open token.
    localparam logic [1:0] OPEN_NONE = 2'd0;
    localparam logic [1:0] OPEN_NAME = 2'd1;
    localparam logic [1:0] OPEN_TEXT = 2'd2;

    // Terminator sets of an open text token.
    localparam logic [1:0] EXCL_TEXT    = 2'd0;
    localparam logic [1:0] EXCL_COMMENT = 2'd1;
    localparam logic [1:0] EXCL_DQ      = 2'd2;
    localparam logic [1:0] EXCL_SQ      = 2'd3;

    // Token kinds.
    localparam logic [3:0] K_LT      = 4'd0;
    localparam logic [3:0] K_GT      = 4'd1;
    localparam logic [3:0] K_LBRACE  = 4'd2;
    localparam logic [3:0] K_RBRACE  = 4'd3;
    localparam logic [3:0] K_EOF     = 4'd4;
    localparam logic [3:0] K_BANG    = 4'd5;
    localparam logic [3:0] K_DASH    = 4'd6;
    localparam logic [3:0] K_SLASH   = 4'd7;
    localparam logic [3:0] K_DQUOT   = 4'd8;
    localparam logic [3:0] K_SQUOT   = 4'd9;
    localparam logic [3:0] K_EQUAL   = 4'd10;
    localparam logic [3:0] K_SPACE   = 4'd11;
    localparam logic [3:0] K_UNKNOWN = 4'd12;
    localparam logic [3:0] K_NAME    = 4'd13;
    localparam logic [3:0] K_TEXT    = 4'd14;

    typedef struct packed {
        logic [3:0]       kind;
        logic [TOK_W-1:0] start;
        logic [TOK_W-1:0] length;
        logic [TOK_W-1:0] line;
        logic             last;
    } t_token;

    // Tokens caused by one byte, in emission order from entry 0.
    typedef struct packed {
        logic [1:0]               cnt;
        t_token [MAX_RES-1:0]     tok;
    } t_res;

endpackage

/* rtl/jmt_ifs.sv */
// Valid/ready stream interfaces for source bytes and tokens.
interface jmt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic [2:0] scan_mode;
    logic       skip_space;

    modport source (output valid, ch, scan_mode, skip_space, input ready);
    modport sink   (input valid, ch, scan_mode, skip_space, output ready);
endinterface

interface jmt_token_if;
    logic                      valid;
    logic                      ready;
    logic [3:0]                token_kind;
    logic [jmt_pkg::TOK_W-1:0] token_start;
    logic [jmt_pkg::TOK_W-1:0] token_length;
    logic [jmt_pkg::TOK_W-1:0] line_number;
    logic                      last;

    modport source (output valid, token_kind, token_start, token_length, line_number, last,
                    input ready);
    modport sink   (input valid, token_kind, token_start, token_length, line_number, last,
                    output ready);
endinterface

/* rtl/jmt_core.sv */
// Tokenizer state and the single-pass decision logic for one source byte.
module jmt_core #(
    parameter int POS_BITS  = jmt_pkg::POS_BITS_DEF,
    parameter int LINE_BITS = jmt_pkg::LINE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_ch,
    input  logic [2:0]    i_scan_mode,
    input  logic          i_skip_space,
    output jmt_pkg::t_res o_res
);

    localparam int TW = jmt_pkg::TOK_W;

    logic [1:0]           r_open_kind,  n_open_kind;
    logic [1:0]           r_open_excl,  n_open_excl;
    logic [POS_BITS-1:0]  r_open_start, n_open_start;
    logic [POS_BITS-1:0]  r_open_len,   n_open_len;
    logic [POS_BITS-1:0]  r_pos,        n_pos;
    logic [LINE_BITS-1:0] r_line,       n_line;

    always_comb begin
        logic       alpha, digit, space, name_cont, text_cont, cont, line_inc;
        logic       do_single, do_empty, do_open;
        logic [3:0] single_kind;
        logic [1:0] open_kind, open_excl, idx;
        logic       sq_mode;
        logic [7:0] quote;
        jmt_pkg::t_res res;

        alpha = (i_ch >= 8'h61 && i_ch <= 8'h7A) || (i_ch >= 8'h41 && i_ch <= 8'h5A);
        digit = (i_ch >= 8'h30 && i_ch <= 8'h39);
        space = (i_ch == jmt_pkg::CH_SPACE) || (i_ch == jmt_pkg::CH_NL) ||
                (i_ch == jmt_pkg::CH_CR) || (i_ch == jmt_pkg::CH_TAB);
        name_cont = alpha || digit || (i_ch == jmt_pkg::CH_DASH) ||
                    (i_ch == jmt_pkg::CH_USCORE) || (i_ch == jmt_pkg::CH_COLON) ||
                    (i_ch == jmt_pkg::CH_DOT);

        unique case (r_open_excl)
            jmt_pkg::EXCL_TEXT:
                text_cont = (i_ch != jmt_pkg::CH_LT) && (i_ch != jmt_pkg::CH_GT) &&
                            (i_ch != jmt_pkg::CH_LBRACE) && (i_ch != jmt_pkg::CH_RBRACE);
            jmt_pkg::EXCL_COMMENT:
                text_cont = (i_ch != jmt_pkg::CH_LT) && (i_ch != jmt_pkg::CH_GT) &&
                            (i_ch != jmt_pkg::CH_BANG) && (i_ch != jmt_pkg::CH_DASH);
            jmt_pkg::EXCL_DQ:
                text_cont = (i_ch != jmt_pkg::CH_DQUOT);
            default:
                text_cont = (i_ch != jmt_pkg::CH_SQUOT);
        endcase
        text_cont = text_cont && (i_ch != jmt_pkg::CH_NUL);

        if (r_open_kind == jmt_pkg::OPEN_NONE) begin
            cont = 1'b0;
        end else if (r_open_kind == jmt_pkg::OPEN_NAME) begin
            cont = name_cont;
        end else begin
            cont = text_cont;
        end

        // Codes four to seven behave as the single-quoted value mode.
        sq_mode = (i_scan_mode > jmt_pkg::MODE_DQ);
        quote   = sq_mode ? jmt_pkg::CH_SQUOT : jmt_pkg::CH_DQUOT;

        do_single   = 1'b0;
        do_empty    = 1'b0;
        do_open     = 1'b0;
        single_kind = jmt_pkg::K_UNKNOWN;
        open_kind   = jmt_pkg::OPEN_TEXT;
        open_excl   = jmt_pkg::EXCL_TEXT;

        priority if (i_skip_space && space) begin
            do_single = 1'b0;
        end else if (i_ch == jmt_pkg::CH_LT) begin
            do_single = 1'b1; single_kind = jmt_pkg::K_LT;
        end else if (i_ch == jmt_pkg::CH_GT) begin
            do_single = 1'b1; single_kind = jmt_pkg::K_GT;
        end else if (i_ch == jmt_pkg::CH_LBRACE) begin
            do_single = 1'b1; single_kind = jmt_pkg::K_LBRACE;
        end else if (i_ch == jmt_pkg::CH_RBRACE) begin
            do_single = 1'b1; single_kind = jmt_pkg::K_RBRACE;
        end else if (i_ch == jmt_pkg::CH_NUL) begin
            do_single = 1'b1; single_kind = jmt_pkg::K_EOF;
        end else if ((i_scan_mode == jmt_pkg::MODE_NAME ||
                      i_scan_mode == jmt_pkg::MODE_COMMENT) && i_ch == jmt_pkg::CH_BANG) begin
            do_single = 1'b1; single_kind = jmt_pkg::K_BANG;
        end else if ((i_scan_mode == jmt_pkg::MODE_NAME ||
                      i_scan_mode == jmt_pkg::MODE_COMMENT) && i_ch == jmt_pkg::CH_DASH) begin
            do_single = 1'b1; single_kind = jmt_pkg::K_DASH;
        end else if (i_scan_mode == jmt_pkg::MODE_NAME) begin
            priority if (i_ch == jmt_pkg::CH_SLASH) begin
                do_single = 1'b1; single_kind = jmt_pkg::K_SLASH;
            end else if (i_ch == jmt_pkg::CH_DQUOT) begin
                do_single = 1'b1; single_kind = jmt_pkg::K_DQUOT;
            end else if (i_ch == jmt_pkg::CH_SQUOT) begin
                do_single = 1'b1; single_kind = jmt_pkg::K_SQUOT;
            end else if (i_ch == jmt_pkg::CH_EQUAL) begin
                do_single = 1'b1; single_kind = jmt_pkg::K_EQUAL;
            end else if (i_ch == jmt_pkg::CH_SPACE) begin
                do_single = 1'b1; single_kind = jmt_pkg::K_SPACE;
            end else if (alpha) begin
                do_open = 1'b1; open_kind = jmt_pkg::OPEN_NAME;
            end else begin
                do_single = 1'b1; single_kind = jmt_pkg::K_UNKNOWN;
            end
        end else if (i_scan_mode == jmt_pkg::MODE_TEXT) begin
            do_open = 1'b1;
        end else if (i_scan_mode == jmt_pkg::MODE_COMMENT) begin
            do_open = 1'b1; open_excl = jmt_pkg::EXCL_COMMENT;
        end else if (i_ch == quote) begin
            // A closing quote straight away: empty value, then the quote itself.
            do_empty    = 1'b1;
            do_single   = 1'b1;
            single_kind = sq_mode ? jmt_pkg::K_SQUOT : jmt_pkg::K_DQUOT;
        end else begin
            do_open   = 1'b1;
            open_excl = sq_mode ? jmt_pkg::EXCL_SQ : jmt_pkg::EXCL_DQ;
        end

        // A newline that is not part of a continued token counts a line
        // when it is skipped or starts a token in a non-name mode.
        line_inc = (i_ch == jmt_pkg::CH_NL) &&
                   (i_skip_space || i_scan_mode != jmt_pkg::MODE_NAME);

        n_open_kind  = r_open_kind;
        n_open_excl  = r_open_excl;
        n_open_start = r_open_start;
        n_open_len   = r_open_len;
        n_pos        = r_pos + POS_BITS'(1);
        n_line       = r_line;
        res          = '0;
        idx          = 2'd0;

        if (cont) begin
            if (r_open_len != '1) begin
                n_open_len = r_open_len + POS_BITS'(1);
            end
            if (r_open_kind != jmt_pkg::OPEN_NAME && i_ch == jmt_pkg::CH_NL &&
                r_line != '1) begin
                n_line = r_line + LINE_BITS'(1);
            end
        end else begin
            if (r_open_kind != jmt_pkg::OPEN_NONE) begin
                res.tok[idx].kind   = (r_open_kind == jmt_pkg::OPEN_NAME) ?
                                      jmt_pkg::K_NAME : jmt_pkg::K_TEXT;
                res.tok[idx].start  = TW'(r_open_start);
                res.tok[idx].length = TW'(r_open_len);
                res.tok[idx].line   = TW'(r_line);
                idx                 = idx + 2'd1;
                n_open_kind         = jmt_pkg::OPEN_NONE;
            end
            if (do_empty) begin
                res.tok[idx].kind   = jmt_pkg::K_TEXT;
                res.tok[idx].start  = TW'(r_pos);
                res.tok[idx].length = '0;
                res.tok[idx].line   = TW'(r_line);
                idx                 = idx + 2'd1;
            end
            if (do_single) begin
                res.tok[idx].kind   = single_kind;
                res.tok[idx].start  = TW'(r_pos);
                res.tok[idx].length = TW'(1);
                res.tok[idx].line   = TW'(r_line);
                idx                 = idx + 2'd1;
            end
            if (do_open) begin
                n_open_kind  = open_kind;
                n_open_excl  = open_excl;
                n_open_start = r_pos;
                n_open_len   = POS_BITS'(1);
            end
            if (line_inc && r_line != '1) begin
                n_line = r_line + LINE_BITS'(1);
            end
        end

        res.cnt = idx;
        if (idx != 2'd0) begin
            res.tok[2'(idx - 2'd1)].last = 1'b1;
        end
        o_res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_kind  <= jmt_pkg::OPEN_NONE;
            r_open_excl  <= jmt_pkg::EXCL_TEXT;
            r_open_start <= '0;
            r_open_len   <= '0;
            r_pos        <= '0;
            r_line       <= LINE_BITS'(1);
        end else if (i_take) begin
            r_open_kind  <= n_open_kind;
            r_open_excl  <= n_open_excl;
            r_open_start <= n_open_start;
            r_open_len   <= n_open_len;
            r_pos        <= n_pos;
            r_line       <= n_line;
        end
    end

endmodule

/* rtl/jmt_out_buf.sv */
// Result register of up to three tokens, drained one beat per cycle while i_pop is high.
module jmt_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  jmt_pkg::t_res   i_res,
    input  logic            i_pop,
    output logic [1:0]      o_cnt,
    output jmt_pkg::t_token o_head
);

    jmt_pkg::t_token [jmt_pkg::MAX_RES-1:0] r_buf;
    logic [1:0]                             r_cnt;

    // The loader only writes when the buffer is empty or its last entry leaves now.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_res.cnt;
        end else if (i_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_res.tok;
        end else if (i_pop) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

    assign o_cnt  = r_cnt;
    assign o_head = r_buf[0];

endmodule

/* rtl/jsx_markup_tokenizer.sv */
// Top level of the markup tokenizer: byte stream in, token stream out.
//
// One source byte enters per beat on i_byte, with its scan mode and its
// skip-whitespace flag; a zero byte marks the end of input. Each byte is
// decided in the cycle it is accepted, against the open-token state, and
// causes zero to three tokens. Those tokens land together in a three-entry
// result register and leave on o_token one beat per cycle while the
// receiver is ready, the final one of a byte flagged by last.
// The first token of an accepted byte is shown on o_token in the next cycle.
// The input takes one byte per cycle while each byte gives at most one token
// and the receiver is ready; a byte that gives more tokens holds the input
// while the result register drains them one token per cycle, and the next
// byte's tokens are taken as its last entry leaves.
// A byte that only extends a name or text token, or is skipped whitespace,
// gives no token and leaves the result register empty.
// When the receiver stalls, finished tokens wait in the result register and
// i_byte.ready drops until it frees up; nothing is lost or repeated.
// Reset clears the open token, sets the byte position to zero and the line
// count to one, and empties the result register.
`include "assert_macros.svh"

module jsx_markup_tokenizer #(
    parameter int POS_BITS  = jmt_pkg::POS_BITS_DEF,
    parameter int LINE_BITS = jmt_pkg::LINE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    jmt_byte_if.sink           i_byte,
    jmt_token_if.source        o_token
);

    logic            take;
    logic            pop;
    logic [1:0]      buf_cnt;
    jmt_pkg::t_res   step_res;
    jmt_pkg::t_token head;

    // The result register may take a new set of tokens when it is empty or
    // when its only remaining token leaves in this cycle.
    assign i_byte.ready = (buf_cnt == 2'd0) || (buf_cnt == 2'd1 && o_token.ready);
    assign take         = i_byte.valid && i_byte.ready;
    assign pop          = o_token.valid && o_token.ready;

    jmt_core #(
        .POS_BITS  (POS_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_ch         (i_byte.ch),
        .i_scan_mode  (i_byte.scan_mode),
        .i_skip_space (i_byte.skip_space),
        .o_res        (step_res)
    );

    jmt_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_res   (step_res),
        .i_pop   (pop),
        .o_cnt   (buf_cnt),
        .o_head  (head)
    );

    assign o_token.valid        = (buf_cnt != 2'd0);
    assign o_token.token_kind   = head.kind;
    assign o_token.token_start  = head.start;
    assign o_token.token_length = head.length;
    assign o_token.line_number  = head.line;
    assign o_token.last         = head.last;

    // A token that is not the last of its byte always has a successor queued.
    `JMT_ASSERT_IMP(a_more_follow, i_clk, i_rst_n, o_token.valid && !o_token.last, buf_cnt >= 2'd2)
    // The final token of a byte is the only one left in the result register.
    `JMT_ASSERT_IMP(a_last_alone, i_clk, i_rst_n, o_token.valid && o_token.last, buf_cnt == 2'd1)
    // After a non-final token leaves, the next token of the same byte is shown.
    `JMT_ASSERT_NXT(a_drain_on, i_clk, i_rst_n, pop && !o_token.last, o_token.valid)

endmodule

/* tb/tb_jmt_checker.sv */
// Token checker: predicts the markup tokenizer from accepted bytes and compares every token beat.
module tb_jmt_checker #(
    parameter int POS_BITS  = jmt_pkg::POS_BITS_DEF,
    parameter int LINE_BITS = jmt_pkg::LINE_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    jmt_byte_if   i_byte,
    jmt_token_if  i_token,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import jmt_pkg::*;

    localparam logic [3:0] NO_TOKEN = 4'hF;

    // Tokenizer state as the predictor sees it.
    logic [1:0]           open_kind;
    logic [1:0]           open_excl;
    logic [POS_BITS-1:0]  open_start;
    logic [POS_BITS-1:0]  open_len;
    logic [POS_BITS-1:0]  byte_pos;
    logic [LINE_BITS-1:0] line_cnt;

    // Tokens still owed by the block, oldest first.
    t_token token_q[$];

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || c == CH_NL || c == CH_CR || c == CH_TAB;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // Whether byte c extends the token that is open.
    function automatic bit extends_open(logic [7:0] c);
        if (open_kind == OPEN_NAME) begin
            return is_alpha(c) || (c >= "0" && c <= "9") || c == CH_DASH ||
                   c == CH_USCORE || c == CH_COLON || c == CH_DOT;
        end
        if (c == CH_NUL) return 1'b0;
        case (open_excl)
            EXCL_TEXT:    return !(c inside {CH_LT, CH_GT, CH_LBRACE, CH_RBRACE});
            EXCL_COMMENT: return !(c inside {CH_LT, CH_GT, CH_BANG, CH_DASH});
            EXCL_DQ:      return c != CH_DQUOT;
            default:      return c != CH_SQUOT;
        endcase
    endfunction

    function automatic t_token make_token(logic [3:0] k, logic [POS_BITS-1:0] s,
                                          logic [POS_BITS-1:0] l);
        t_token t;
        t.kind   = k;
        t.start  = TOK_W'(s);
        t.length = TOK_W'(l);
        t.line   = TOK_W'(line_cnt);
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic string describe(t_token t);
        return $sformatf("kind=%0d start=%0d length=%0d line=%0d last=%0b",
                         t.kind, t.start, t.length, t.line, t.last);
    endfunction

    task automatic count_line();
        if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
    endtask

    task automatic open_token(logic [1:0] k, logic [1:0] excl, logic [POS_BITS-1:0] s);
        open_kind  = k;
        open_excl  = excl;
        open_start = s;
        open_len   = 1;
    endtask

    // Works out the tokens that one accepted byte causes and queues them.
    task automatic tokenize_byte(input logic [7:0] c, input logic [2:0] m, input logic skip);
        logic [POS_BITS-1:0] p;
        logic [7:0]          quote;
        logic [3:0]          single;
        t_token              made [MAX_RES];
        int                  n;
        p        = byte_pos;
        byte_pos = p + 1'b1;
        single   = NO_TOKEN;
        n        = 0;
        if (open_kind != OPEN_NONE) begin
            if (extends_open(c)) begin
                if (open_len != '1) open_len = open_len + 1'b1;
                if (open_kind != OPEN_NAME && c == CH_NL) count_line();
                return;
            end
            made[n] = make_token(open_kind == OPEN_NAME ? K_NAME : K_TEXT, open_start, open_len);
            n++;
            open_kind = OPEN_NONE;
        end
        if (skip && is_space(c)) begin
            if (c == CH_NL) count_line();
        end else if (c == CH_LT)     single = K_LT;
        else if (c == CH_GT)         single = K_GT;
        else if (c == CH_LBRACE)     single = K_LBRACE;
        else if (c == CH_RBRACE)     single = K_RBRACE;
        else if (c == CH_NUL)        single = K_EOF;
        else if ((m == MODE_NAME || m == MODE_COMMENT) && c == CH_BANG) single = K_BANG;
        else if ((m == MODE_NAME || m == MODE_COMMENT) && c == CH_DASH) single = K_DASH;
        else if (m == MODE_NAME) begin
            if (c == CH_SLASH)      single = K_SLASH;
            else if (c == CH_DQUOT) single = K_DQUOT;
            else if (c == CH_SQUOT) single = K_SQUOT;
            else if (c == CH_EQUAL) single = K_EQUAL;
            else if (c == CH_SPACE) single = K_SPACE;
            else if (is_alpha(c))   open_token(OPEN_NAME, EXCL_TEXT, p);
            else                    single = K_UNKNOWN;
        end else begin
            if (c == CH_NL) count_line();
            if (m == MODE_TEXT) begin
                open_token(OPEN_TEXT, EXCL_TEXT, p);
            end else if (m == MODE_COMMENT) begin
                open_token(OPEN_TEXT, EXCL_COMMENT, p);
            end else begin
                // Modes above double quote all behave as single-quoted values.
                quote = (m == MODE_DQ) ? CH_DQUOT : CH_SQUOT;
                if (c == quote) begin
                    made[n] = make_token(K_TEXT, p, '0);
                    n++;
                    single = (m == MODE_DQ) ? K_DQUOT : K_SQUOT;
                end else begin
                    open_token(OPEN_TEXT, (m == MODE_DQ) ? EXCL_DQ : EXCL_SQ, p);
                end
            end
        end
        if (single != NO_TOKEN) begin
            made[n] = make_token(single, p, 1);
            n++;
        end
        if (n > 0) made[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) token_q.push_back(made[i]);
    endtask

    always @(posedge i_clk) begin : watch
        t_token got;
        t_token want;
        if (!i_rst_n) begin
            open_kind    = OPEN_NONE;
            open_excl    = EXCL_TEXT;
            open_start   = '0;
            open_len     = '0;
            byte_pos     = '0;
            line_cnt     = 1;
            o_fail_count = 0;
            token_q.delete();
        end else begin
            if (i_byte.valid && i_byte.ready)
                tokenize_byte(i_byte.ch, i_byte.scan_mode, i_byte.skip_space);
            if (i_token.valid && i_token.ready) begin
                got.kind   = i_token.token_kind;
                got.start  = i_token.token_start;
                got.length = i_token.token_length;
                got.line   = i_token.line_number;
                got.last   = i_token.last;
                if (token_q.size() == 0) begin
                    $display("%0t: token beat with none expected, got %s", $time, describe(got));
                    o_fail_count++;
                end else begin
                    want = token_q.pop_front();
                    if (got.kind !== want.kind || got.start !== want.start ||
                        got.length !== want.length || got.line !== want.line ||
                        got.last !== want.last) begin
                        $display("%0t: token mismatch, expected %s, got %s",
                                 $time, describe(want), describe(got));
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = token_q.size();
    end

endmodule

/* tb/tb_jsx_markup_tokenizer.sv */
// Testbench top for the markup tokenizer: clock, reset, byte stimulus, token back-pressure and verdict.
module tb_jsx_markup_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import jmt_pkg::*;

    // The package names the first four scan modes; two of the rest are spelt out here.
    localparam logic [2:0] MODE_SQ    = 3'd4;
    localparam logic [2:0] MODE_UNDEF = 3'd7;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   n_sent;
    // Set for the closing part of the run, where neither side idles.
    bit   calm;
    // Asks the token receiver for one long hold-off.
    bit   long_hold;

    jmt_byte_if  byte_ch ();
    jmt_token_if tok_ch ();

    jsx_markup_tokenizer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_token (tok_ch)
    );

    tb_jmt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (byte_ch),
        .i_token      (tok_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous ceiling for about two hundred bytes of up to three token beats
    // each, with their idle bursts and the long hold-off.
    initial begin
        #400_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Token receiver. Ready is changed only at falling edges; short random
    // stalls, one long hold-off on request so that the result register fills
    // and the byte side is pushed back, and no stalls at all once the closing
    // part of the run begins.
    initial begin : receiver
        int low_left;
        low_left     = 0;
        tok_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                low_left  = 60;
                long_hold = 1'b0;
            end else if (calm) begin
                low_left = 0;
            end else if (low_left == 0 && $urandom_range(0, 5) == 0) begin
                low_left = $urandom_range(1, 4);
            end
            tok_ch.ready <= (low_left == 0);
            if (low_left > 0) low_left--;
        end
    end

    function automatic logic [7:0] pick_alpha();
        if ($urandom_range(0, 1) != 0) return 8'($urandom_range("a", "z"));
        return 8'($urandom_range("A", "Z"));
    endfunction

    // Any byte that may follow the first letter of a name.
    function automatic logic [7:0] pick_name_char();
        case ($urandom_range(0, 7))
            0:       return CH_DASH;
            1:       return CH_USCORE;
            2:       return CH_COLON;
            3:       return CH_DOT;
            4, 5:    return 8'($urandom_range("0", "9"));
            default: return pick_alpha();
        endcase
    endfunction

    // Printable content with a fair share of whitespace and line breaks.
    function automatic logic [7:0] pick_text_char();
        case ($urandom_range(0, 9))
            0:       return CH_NL;
            1:       return CH_SPACE;
            2:       return ($urandom_range(0, 1) != 0) ? CH_TAB : CH_CR;
            default: return 8'($urandom_range(33, 126));
        endcase
    endfunction

    // Offers one byte and returns at the falling edge after its beat. Valid
    // is left high, so back-to-back bytes never lower it within a step; an
    // idle burst, when one is drawn, lowers it first.
    task automatic send_byte(input logic [7:0] c, input logic [2:0] m, input logic s);
        if (!calm && $urandom_range(0, 4) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.ch         <= c;
        byte_ch.scan_mode  <= m;
        byte_ch.skip_space <= s;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    // A tag or attribute name, sent in name mode with whitespace skipped.
    task automatic send_name();
        int len;
        len = $urandom_range(1, 6);
        send_byte(pick_alpha(), MODE_NAME, 1'b1);
        repeat (len - 1) send_byte(pick_name_char(), MODE_NAME, 1'b1);
    endtask

    task automatic send_run(input logic [2:0] m, input int len);
        repeat (len) send_byte(pick_text_char(), m, 1'b0);
    endtask

    initial begin : stimulus
        int           goal;
        int           attrs;
        logic [2:0]   qmode;
        logic [7:0]   quote;

        byte_ch.valid      = 1'b0;
        byte_ch.ch         = CH_NUL;
        byte_ch.scan_mode  = MODE_NAME;
        byte_ch.skip_space = 1'b0;
        i_rst_n            = 1'b0;
        calm               = 1'b0;
        long_hold          = 1'b0;
        n_sent             = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: every token kind, a name and a text closed by the
        // byte that starts the next token, the three-token byte (a name ended
        // by a quote that is also an empty value), a line break inside a
        // value, skipped and counted whitespace, an undefined scan mode and
        // the end marker.
        send_byte(CH_LT,     MODE_NAME,    1'b1);
        send_byte("d",       MODE_NAME,    1'b1);
        send_byte("i",       MODE_NAME,    1'b1);
        send_byte("v",       MODE_NAME,    1'b1);
        send_byte(CH_SPACE,  MODE_NAME,    1'b1);
        send_byte("c",       MODE_NAME,    1'b1);
        send_byte(CH_DQUOT,  MODE_DQ,      1'b0);
        send_byte("x",       MODE_DQ,      1'b0);
        send_byte(CH_NL,     MODE_DQ,      1'b0);
        send_byte(CH_DQUOT,  MODE_NAME,    1'b0);
        send_byte(CH_EQUAL,  MODE_NAME,    1'b1);
        send_byte(CH_SQUOT,  MODE_SQ,      1'b0);
        send_byte(CH_SQUOT,  MODE_NAME,    1'b0);
        send_byte(CH_SLASH,  MODE_NAME,    1'b1);
        send_byte(CH_GT,     MODE_NAME,    1'b1);
        send_byte(CH_NL,     MODE_TEXT,    1'b1);
        send_byte("a",       MODE_TEXT,    1'b0);
        send_byte(CH_LBRACE, MODE_TEXT,    1'b0);
        send_byte(CH_RBRACE, MODE_TEXT,    1'b0);
        send_byte(CH_BANG,   MODE_COMMENT, 1'b0);
        send_byte(CH_NL,     MODE_COMMENT, 1'b0);
        send_byte(CH_DASH,   MODE_COMMENT, 1'b0);
        send_byte(CH_TAB,    MODE_NAME,    1'b0);
        send_byte(CH_SPACE,  MODE_NAME,    1'b0);
        send_byte(8'hFF,     MODE_UNDEF,   1'b0);
        send_byte(CH_NUL,    MODE_NAME,    1'b0);

        // Random part: mostly well-formed markup with random content, the
        // rest loose whitespace and raw noise over every byte and mode code.
        // The long receiver hold-off lands at its start.
        long_hold = 1'b1;
        goal      = n_sent + 130;
        while (n_sent < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    send_byte(CH_LT, MODE_NAME, 1'b1);
                    if ($urandom_range(0, 3) == 0) send_byte(CH_SLASH, MODE_NAME, 1'b1);
                    send_name();
                    attrs = $urandom_range(0, 2);
                    repeat (attrs) begin
                        send_byte(CH_SPACE, MODE_NAME, 1'b1);
                        send_name();
                        send_byte(CH_EQUAL, MODE_NAME, 1'b1);
                        qmode = ($urandom_range(0, 1) != 0) ? MODE_DQ : MODE_SQ;
                        quote = (qmode == MODE_DQ) ? CH_DQUOT : CH_SQUOT;
                        send_byte(quote, MODE_NAME, 1'b1);
                        send_run(qmode, $urandom_range(0, 5));
                        // The closing quote is seen either as a tag character
                        // or, still in value mode, as a fresh empty value.
                        send_byte(quote, ($urandom_range(0, 1) != 0) ? qmode : MODE_NAME, 1'b0);
                    end
                    if ($urandom_range(0, 3) == 0) send_byte(CH_SLASH, MODE_NAME, 1'b1);
                    send_byte(CH_GT, MODE_NAME, 1'b1);
                end
                3, 4: begin
                    send_run(MODE_TEXT, $urandom_range(1, 8));
                end
                5: begin
                    send_byte(CH_LBRACE, MODE_TEXT, 1'b0);
                    send_run(MODE_TEXT, $urandom_range(0, 4));
                    send_byte(CH_RBRACE, MODE_TEXT, 1'b0);
                end
                6: begin
                    send_byte(CH_LT,   MODE_NAME,    1'b1);
                    send_byte(CH_BANG, MODE_NAME,    1'b1);
                    send_byte(CH_DASH, MODE_COMMENT, 1'b0);
                    send_byte(CH_DASH, MODE_COMMENT, 1'b0);
                    send_run(MODE_COMMENT, $urandom_range(0, 6));
                    send_byte(CH_DASH, MODE_COMMENT, 1'b0);
                    send_byte(CH_DASH, MODE_COMMENT, 1'b0);
                    send_byte(CH_GT,   MODE_COMMENT, 1'b0);
                end
                7: begin
                    repeat ($urandom_range(1, 3))
                        send_byte(($urandom_range(0, 1) != 0) ? CH_NL : CH_SPACE,
                                  3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                                  1'($urandom_range(0, 1)));
                end
            endcase
        end

        // Closing part, no idling on either side. A text token carrying
        // several line breaks, then a few tokens after it that show the
        // advanced line count, and the end marker.
        calm = 1'b1;
        send_byte("a", MODE_TEXT, 1'b0);
        repeat (8) send_byte(CH_NL, MODE_TEXT, 1'b0);
        send_byte(CH_LT,    MODE_NAME, 1'b1);
        send_byte("b",      MODE_NAME, 1'b1);
        send_byte(CH_EQUAL, MODE_NAME, 1'b1);
        send_byte(CH_NL,    MODE_TEXT, 1'b1);
        send_byte(CH_NL,    MODE_TEXT, 1'b0);
        send_byte(CH_NUL,   MODE_NAME, 1'b0);
        byte_ch.valid <= 1'b0;

        // Drain, then wait for any stray beat to show itself.
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
